FILE: rtl/uwdf_pkg.sv
package uwdf_pkg;

  localparam int UW_LENGTH     = 40;
  localparam int PAYLOAD_BYTES = 256;
  localparam int WORD_BITS     = 10;
  localparam int QUEUE_DEPTH   = 4;

  localparam int AE_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 40;
  localparam int SCORE_W  = $clog2(UW_LENGTH + 1);
  localparam int SUM_W    = ((SCORE_W > AE_W) ? SCORE_W : AE_W) + 1;
  localparam int WC_W     = $clog2(PAYLOAD_BYTES + 2);
  localparam int BIT_W    = $clog2(WORD_BITS);
  localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [UW_LENGTH-1:0] UW_PATTERN_RST = UW_LENGTH'(40'd552942332758);
  localparam logic [AE_W-1:0]      ALLOWED_ERR_RST = AE_W'(5);
  localparam logic [15:0]          CRC_INIT        = 16'hFFFF;

  localparam logic RK_BYTE    = 1'b0;
  localparam logic RK_VERDICT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UW_PATTERN     = 1'b0,
    REG_ALLOWED_ERRORS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_CRC_LO  = 2'd1,
    EV_CRC_HI  = 2'd2
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic [7:0]  data;
    logic [7:0]  idx;
  } ev_t;

  function automatic logic [SCORE_W-1:0] popcount(input logic [UW_LENGTH-1:0] v);
    logic [SCORE_W-1:0] s;
    s = '0;
    for (int i = 0; i < UW_LENGTH; i++) begin
      s = s + SCORE_W'(v[i]);
    end
    return s;
  endfunction

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ {4'b0, x[7:4]};
    return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
  endfunction

endpackage

FILE: rtl/uwdf_front.sv
module uwdf_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_rx_bit,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [uwdf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [uwdf_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              q_full,
  output logic                              q_push,
  output uwdf_pkg::ev_t                     q_ev
);

  logic [uwdf_pkg::UW_LENGTH-1:0] pat_r;
  logic [uwdf_pkg::AE_W-1:0]      ae_r;
  logic [uwdf_pkg::UW_LENGTH-1:0] win_r, win_nxt, win_shift;
  logic                           locked_r, locked_nxt;
  logic [uwdf_pkg::BIT_W-1:0]     bit_cnt_r, bit_cnt_nxt;
  logic [uwdf_pkg::WC_W-1:0]      word_cnt_r, word_cnt_nxt;
  logic [uwdf_pkg::WORD_BITS-1:0] sh_r, sh_nxt;
  logic [uwdf_pkg::SCORE_W-1:0]   score;
  logic [uwdf_pkg::SUM_W-1:0]     sum;
  logic                           lock_hit;
  logic                           accept;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_comb begin
    win_shift = {in_rx_bit, win_r[uwdf_pkg::UW_LENGTH-1:1]};
    score     = uwdf_pkg::popcount(~(win_shift ^ pat_r));
    sum       = uwdf_pkg::SUM_W'(score) + uwdf_pkg::SUM_W'(ae_r);
    lock_hit  = sum > uwdf_pkg::SUM_W'(uwdf_pkg::UW_LENGTH);

    win_nxt      = win_r;
    locked_nxt   = locked_r;
    bit_cnt_nxt  = bit_cnt_r;
    word_cnt_nxt = word_cnt_r;
    sh_nxt       = sh_r;
    q_push       = 1'b0;
    q_ev.data    = sh_r[uwdf_pkg::WORD_BITS-1:2];
    q_ev.idx     = word_cnt_r[7:0];
    if (word_cnt_r < uwdf_pkg::WC_W'(uwdf_pkg::PAYLOAD_BYTES)) begin
      q_ev.kind = uwdf_pkg::EV_PAYLOAD;
    end else if (word_cnt_r == uwdf_pkg::WC_W'(uwdf_pkg::PAYLOAD_BYTES)) begin
      q_ev.kind = uwdf_pkg::EV_CRC_LO;
    end else begin
      q_ev.kind = uwdf_pkg::EV_CRC_HI;
    end

    if (accept) begin
      if (!locked_r) begin
        win_nxt = win_shift;
        if (lock_hit) begin
          locked_nxt   = 1'b1;
          bit_cnt_nxt  = '0;
          word_cnt_nxt = '0;
        end
      end else if (bit_cnt_r == uwdf_pkg::BIT_W'(uwdf_pkg::WORD_BITS - 1)) begin
        q_push      = 1'b1;
        bit_cnt_nxt = '0;
        if (word_cnt_r == uwdf_pkg::WC_W'(uwdf_pkg::PAYLOAD_BYTES + 1)) begin
          locked_nxt   = 1'b0;
          word_cnt_nxt = '0;
        end else begin
          word_cnt_nxt = word_cnt_r + 1'b1;
        end
      end else begin
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        sh_nxt      = {in_rx_bit, sh_r[uwdf_pkg::WORD_BITS-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r      <= uwdf_pkg::UW_PATTERN_RST;
      ae_r       <= uwdf_pkg::ALLOWED_ERR_RST;
      win_r      <= '0;
      locked_r   <= 1'b0;
      bit_cnt_r  <= '0;
      word_cnt_r <= '0;
    end else begin
      win_r      <= win_nxt;
      locked_r   <= locked_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      word_cnt_r <= word_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        case (uwdf_pkg::cfg_reg_t'(cfg_index))
          uwdf_pkg::REG_UW_PATTERN:     pat_r <= cfg_data[uwdf_pkg::UW_LENGTH-1:0];
          uwdf_pkg::REG_ALLOWED_ERRORS: ae_r  <= cfg_data[uwdf_pkg::AE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  a_lock_clears_counters: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(locked_r) |-> (bit_cnt_r == '0 && word_cnt_r == '0))
    else $error("lock did not start a fresh packet");

endmodule

FILE: rtl/uwdf_queue.sv
module uwdf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  uwdf_pkg::ev_t push_ev,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output uwdf_pkg::ev_t head
);

  uwdf_pkg::ev_t                 mem_r [uwdf_pkg::QUEUE_DEPTH];
  logic [uwdf_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [uwdf_pkg::QCNT_W-1:0]   count_r;

  assign full      = count_r == uwdf_pkg::QCNT_W'(uwdf_pkg::QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_ev;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= uwdf_pkg::QCNT_W'(uwdf_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

endmodule

FILE: rtl/uwdf_back.sv
module uwdf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_not_empty,
  input  uwdf_pkg::ev_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_result_kind,
  output logic [7:0]    out_payload_byte,
  output logic [7:0]    out_byte_index,
  output logic          out_crc_ok,
  output logic          out_last
);

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic        ok_r, ok_nxt;
  logic        last_r, last_nxt;

  assign q_pop = q_not_empty && (!out_valid_r || out_ready);

  always_comb begin
    crc_nxt       = crc_r;
    crc_lo_nxt    = crc_lo_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    idx_nxt       = idx_r;
    ok_nxt        = ok_r;
    last_nxt      = last_r;
    if (q_pop) begin
      case (q_head.kind)
        uwdf_pkg::EV_PAYLOAD: begin
          crc_nxt       = uwdf_pkg::crc_update(crc_r, q_head.data);
          out_valid_nxt = 1'b1;
          kind_nxt      = uwdf_pkg::RK_BYTE;
          byte_nxt      = q_head.data;
          idx_nxt       = q_head.idx;
          ok_nxt        = 1'b0;
          last_nxt      = 1'b0;
        end
        uwdf_pkg::EV_CRC_LO: begin
          crc_lo_nxt = q_head.data;
        end
        uwdf_pkg::EV_CRC_HI: begin
          crc_nxt       = uwdf_pkg::CRC_INIT;
          out_valid_nxt = 1'b1;
          kind_nxt      = uwdf_pkg::RK_VERDICT;
          byte_nxt      = '0;
          idx_nxt       = '0;
          ok_nxt        = {q_head.data, crc_lo_r} == crc_r;
          last_nxt      = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= uwdf_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_lo_r <= crc_lo_nxt;
    kind_r   <= kind_nxt;
    byte_r   <= byte_nxt;
    idx_r    <= idx_nxt;
    ok_r     <= ok_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_payload_byte = byte_r;
  assign out_byte_index   = idx_r;
  assign out_crc_ok       = ok_r;
  assign out_last         = last_r;

  a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.kind == uwdf_pkg::EV_CRC_HI) |=> crc_r == uwdf_pkg::CRC_INIT)
    else $error("crc not restarted after verdict");

endmodule

FILE: rtl/uw_sync_rs232_deframer_crc16_unit.sv
// channel | ports                                  | handshake
// in      | in_rx_bit                              | in_valid / in_ready
// out     | out_result_kind, out_payload_byte,     | out_valid / out_ready
//         | out_byte_index, out_crc_ok, out_last   |
// cfg     | cfg_index, cfg_data                    | cfg_valid / cfg_ready
//
// one bit per cycle while in_ready is high; a completed word enters the four-entry
// event queue and moves into the output register once that register is free
// in_ready drops only while the event queue is full, cfg_ready is always high
// reset (rst_n low, synchronous) returns to searching with crc 0xffff
// an output stall drops in_ready only once four completed words wait in the queue
module uw_sync_rs232_deframer_crc16_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_rx_bit,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_result_kind,
  output logic [7:0]                     out_payload_byte,
  output logic [7:0]                     out_byte_index,
  output logic                           out_crc_ok,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uwdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uwdf_pkg::CFG_W-1:0]     cfg_data
);

  logic          q_full, q_push, q_pop, q_not_empty;
  uwdf_pkg::ev_t q_ev, q_head;

  uwdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_rx_bit (in_rx_bit),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ev      (q_ev)
  );

  uwdf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_ev   (q_ev),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  uwdf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_crc_ok       (out_crc_ok),
    .out_last         (out_last)
  );

endmodule
